// File: design/gdda_pkg.sv
// Shared types, constants and a helper function of the grid ray traversal unit.
package gdda_pkg;

  localparam int MAP_MAX_W_DEF  = 64;
  localparam int MAP_MAX_H_DEF  = 64;
  localparam int STEP_LIMIT_DEF = 30;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_WALL  = 8'h23;
  localparam logic [7:0] CH_EXIT  = 8'h45;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CAST  = 2'd2;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_NORTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
  localparam int                 CORDIC_N = 32;
  localparam logic [22:0]        HIT_MAX  = 23'd4194304;
  localparam logic [23:0]        DIST_MAX = 24'd16777215;
  localparam logic [32:0]        DELTA_SAT = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [7:0]  cell_symbol;
    logic [21:0] origin_x;
    logic [21:0] origin_y;
    logic [15:0] ray_angle;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  symbol;
    logic        solid;
    logic [1:0]  face_side;
    logic [22:0] hit_x;
    logic [22:0] hit_y;
    logic [15:0] tex_u;
    logic [23:0] distance;
  } rsp_t;

  typedef struct packed {
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // capture request
    logic cordic_init;
    logic cordic_step;
    logic dir_finish;  // round and apply quadrant
    logic div_init;
    logic div_step;
    logic div_done;    // store delta x or y
    logic div_sel_y;
    logic side_mul;    // start side distances
    logic dda_step;
    logic dda_check;
    logic hit_mul;
    logic hit_final;
    logic map_write;
    logic map_read;
    logic query_done;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic div_last;
    logic found;
    logic steps_out;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/gdda_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface gdda_req_if import gdda_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gdda_rsp_if import gdda_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gdda_cfg_if import gdda_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/gdda_datapath.sv
// Datapath: map memory, CORDIC, reciprocal divider, DDA walk and hit math.
module gdda_datapath import gdda_pkg::*; #(
  parameter int MAP_MAX_W  = MAP_MAX_W_DEF,
  parameter int MAP_MAX_H  = MAP_MAX_H_DEF,
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  req_t       req,
  input  logic [6:0] map_width,
  input  logic [6:0] map_height,
  output rsp_t       rsp
);
  localparam int DEPTH = MAP_MAX_W * MAP_MAX_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAP_MAX_W + 1);
  localparam int HW    = $clog2(MAP_MAX_H + 1);
  localparam int SW    = $clog2(STEP_LIMIT + 2);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  // clamped geometry
  logic [WW-1:0] used_w;
  logic [HW-1:0] used_h;
  always_comb begin
    if (map_width == 7'd0) used_w = WW'(1);
    else if (32'(map_width) > MAP_MAX_W) used_w = WW'(MAP_MAX_W);
    else used_w = WW'(map_width);
    if (map_height == 7'd0) used_h = HW'(1);
    else if (32'(map_height) > MAP_MAX_H) used_h = HW'(MAP_MAX_H);
    else used_h = HW'(map_height);
  end

  // request capture
  req_t r;
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  // cell address selection: query/write uses request cell, cast uses walk cell
  logic signed [16:0] gx, gy;
  logic signed [16:0] ax, ay;
  logic               in_map;
  logic [AW-1:0]      addr;
  logic [AW+8:0]      addr_full;
  always_comb begin
    if (cmd.dda_step || cmd.dda_check) begin
      ax = gx;
      ay = gy;
    end else begin
      ax = {r.cell_x[15], r.cell_x};
      ay = {r.cell_y[15], r.cell_y};
    end
    in_map = !ax[16] && !ay[16] && (ax < 17'(used_w)) && (ay < 17'(used_h));
    addr_full = (AW+9)'(ay[8:0]) * (AW+9)'(used_w) + (AW+9)'(ax[8:0]);
    addr = addr_full[AW-1:0];
  end

  // map memory with a clearing pass
  logic [AW-1:0] clr_addr;
  logic          clr_last;
  assign clr_last = (clr_addr == AW'(DEPTH - 1));
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + AW'(1);
  end

  logic          in_map_q;
  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_addr] <= CH_SPACE;
    else if (cmd.map_write && in_map) mem[addr] <= r.cell_symbol;
    rd_data <= mem[addr];
    in_map_q <= in_map;
  end
  logic [7:0] cell_sym;
  assign cell_sym = in_map_q ? rd_data : CH_WALL;

  // CORDIC
  logic [31:0]        ang_a;
  logic [1:0]         quad;
  logic [31:0]        rem_r;
  assign ang_a = {r.ray_angle, 16'd0};
  assign quad  = 2'((ang_a + 32'h2000_0000) >> 30);
  assign rem_r = ang_a - {quad, 30'd0};

  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0]         ci;
  logic               zero_rem;
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= CORDIC_K;
      cy <= '0;
      cz <= 34'(signed'(rem_r));
      ci <= '0;
      zero_rem <= (rem_r == 32'd0);
    end else if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - (cy >>> ci);
        cy <= cy + (cx >>> ci);
        cz <= cz - 34'(atan_turn(ci));
      end else begin
        cx <= cx + (cy >>> ci);
        cy <= cy - (cx >>> ci);
        cz <= cz + 34'(atan_turn(ci));
      end
      ci <= ci + 5'd1;
    end
  end
  assign sts.cordic_last = (ci == 5'(CORDIC_N - 1));

  logic signed [35:0] cc, ss;
  logic signed [18:0] cr, sr;
  logic signed [18:0] dx, dy;
  always_comb begin
    cc = zero_rem ? 36'sd1073741824 : cx;
    ss = zero_rem ? 36'sd0 : cy;
    cr = 19'((cc + 36'sd8192) >>> 14);
    sr = 19'((ss + 36'sd8192) >>> 14);
  end
  always_ff @(posedge clk) begin
    if (cmd.dir_finish) begin
      case (quad)
        2'd0: begin dx <= cr;  dy <= sr;  end
        2'd1: begin dx <= -sr; dy <= cr;  end
        2'd2: begin dx <= -cr; dy <= -sr; end
        default: begin dx <= sr; dy <= -cr; end
      endcase
    end
  end
  logic [17:0] mdx, mdy;
  assign mdx = dx[18] ? 18'(-dx) : 18'(dx);
  assign mdy = dy[18] ? 18'(-dy) : 18'(dy);

  // restoring divider: 2^32 / m, one quotient bit per cycle
  logic [32:0] rem_d;
  logic [32:0] quo;
  logic [5:0]  di;
  logic [17:0] dm;
  logic [33:0] trial;
  assign dm    = cmd.div_sel_y ? mdy : mdx;
  assign trial = {rem_d, (di == 6'd0)} - 34'(dm);
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_d <= '0;
      quo   <= '0;
      di    <= '0;
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem_d <= trial[32:0];
        quo   <= {quo[31:0], 1'b1};
      end else begin
        rem_d <= {rem_d[31:0], (di == 6'd0)};
        quo   <= {quo[31:0], 1'b0};
      end
      di <= di + 6'd1;
    end
  end
  assign sts.div_last = (di == 6'd33);

  logic [31:0] delta_val;
  assign delta_val = (dm == 18'd0 || quo > DELTA_SAT) ? 32'hFFFF_FFFF : quo[31:0];
  logic [31:0] ddx, ddy;
  always_ff @(posedge clk) begin
    if (cmd.div_done) begin
      if (cmd.div_sel_y) ddy <= delta_val;
      else ddx <= delta_val;
    end
  end

  // DDA
  logic [16:0] frx, fry;
  assign frx = dx[18] ? {1'b0, r.origin_x[15:0]} : 17'd65536 - 17'(r.origin_x[15:0]);
  assign fry = dy[18] ? {1'b0, r.origin_y[15:0]} : 17'd65536 - 17'(r.origin_y[15:0]);

  logic [39:0]  sdx, sdy;
  logic [39:0]  t;
  logic         xface;
  logic [SW-1:0] nstep;
  logic [7:0]   sym;
  logic signed [1:0] sx, sy;
  assign sx = dx[18] ? -2'sd1 : (dx == 19'sd0 ? 2'sd0 : 2'sd1);
  assign sy = dy[18] ? -2'sd1 : (dy == 19'sd0 ? 2'sd0 : 2'sd1);
  logic [48:0] prx, pry;
  assign prx = 49'(frx) * 49'(ddx);
  assign pry = 49'(fry) * 49'(ddy);

  always_ff @(posedge clk) begin
    if (cmd.side_mul) begin
      sdx   <= 40'(prx >> 16);
      sdy   <= 40'(pry >> 16);
      gx    <= {11'd0, r.origin_x[21:16]};
      gy    <= {11'd0, r.origin_y[21:16]};
      nstep <= '0;
    end else if (cmd.dda_step) begin
      if (sdx < sdy) begin
        t <= sdx; sdx <= sdx + 40'(ddx); gx <= gx + 17'(sx); xface <= 1'b1;
      end else begin
        t <= sdy; sdy <= sdy + 40'(ddy); gy <= gy + 17'(sy); xface <= 1'b0;
      end
      nstep <= nstep + SW'(1);
    end
    if (cmd.dda_check) sym <= cell_sym;
  end
  assign sts.found = (cell_sym != CH_SPACE);
  assign sts.steps_out = (nstep == SW'(STEP_LIMIT + 1));

  // hit point
  logic [17:0] mo;
  logic [57:0] pt;
  logic [41:0] sc;
  always_ff @(posedge clk) begin
    if (cmd.hit_mul) pt <= 58'(t) * 58'(xface ? mdy : mdx);
  end
  assign sc = 42'((pt + 58'd32768) >> 16);
  assign mo = '0;

  logic signed [43:0] hxv, hyv, uv, oth;
  logic signed [43:0] scs;
  always_comb begin
    scs = xface ? (dy[18] ? -44'(sc) : 44'(sc)) : (dx[18] ? -44'(sc) : 44'(sc));
    if (xface) begin
      hxv = 44'(sx[1] ? gx + 17'sd1 : gx) <<< 16;
      hyv = 44'(r.origin_y) + scs;
      uv  = hyv - (44'(gy) <<< 16);
      oth = hyv;
    end else begin
      hyv = 44'(sy[1] ? gy + 17'sd1 : gy) <<< 16;
      hxv = 44'(r.origin_x) + scs;
      uv  = hxv - (44'(gx) <<< 16);
      oth = hxv;
    end
  end

  function automatic logic [22:0] clamp_hit(input logic signed [43:0] v);
    if (v < 0) return '0;
    if (v > 44'(HIT_MAX)) return HIT_MAX;
    return v[22:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) rsp <= '0;
    else if (cmd.query_done) begin
      rsp.symbol <= cell_sym;
      rsp.solid  <= (cell_sym != CH_SPACE) && (cell_sym != CH_EXIT);
    end else if (cmd.hit_final) begin
      rsp.hit       <= 1'b1;
      rsp.symbol    <= sym;
      rsp.solid     <= 1'b0;
      rsp.face_side <= xface ? (sx[1] ? FACE_EAST : FACE_WEST)
                             : (sy[1] ? FACE_SOUTH : FACE_NORTH);
      rsp.hit_x     <= clamp_hit(hxv);
      rsp.hit_y     <= clamp_hit(hyv);
      rsp.tex_u     <= (uv < 0) ? 16'd0 : ((uv > 44'sd65535) ? 16'hFFFF : uv[15:0]);
      rsp.distance  <= (t > 40'(DIST_MAX)) ? DIST_MAX : t[23:0];
    end
  end
  logic unused;
  assign unused = ^{mo, oth, clr_last, cmd.map_read};
endmodule

// File: design/gdda_ctrl.sv
// Controller state machine sequencing requests through the datapath.
module gdda_ctrl import gdda_pkg::*; #(
  parameter int MAP_MAX_W = MAP_MAX_W_DEF,
  parameter int MAP_MAX_H = MAP_MAX_H_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);
  localparam int AW = $clog2(MAP_MAX_W * MAP_MAX_H);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_QREAD, S_QDONE, S_CORDIC, S_DIR, S_DIVX, S_DIVY,
    S_SIDE, S_STEP, S_FETCH, S_CHECK, S_HMUL, S_HFIN, S_OUT
  } state_t;

  state_t      state;
  logic [1:0]  rtype;
  logic [AW-1:0] clr_cnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load        = in_valid && in_ready;
    cmd.clear       = (state == S_CLEAR);
    cmd.map_write   = (state == S_DECODE) && (rtype == REQ_WRITE);
    cmd.map_read    = (state == S_QREAD);
    cmd.query_done  = (state == S_QDONE);
    cmd.cordic_init = (state == S_DECODE) && (rtype == REQ_CAST);
    cmd.cordic_step = (state == S_CORDIC);
    cmd.dir_finish  = (state == S_DIR);
    cmd.div_sel_y   = (state == S_DIVY);
    cmd.div_init    = (state == S_DIR) || ((state == S_DIVX) && sts.div_last);
    cmd.div_step    = ((state == S_DIVX) || (state == S_DIVY)) && !sts.div_last;
    cmd.div_done    = ((state == S_DIVX) || (state == S_DIVY)) && sts.div_last;
    cmd.side_mul    = (state == S_SIDE);
    cmd.dda_step    = (state == S_STEP);
    cmd.dda_check   = (state == S_FETCH) || (state == S_CHECK);
    cmd.hit_mul     = (state == S_HMUL);
    cmd.hit_final   = (state == S_HFIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      rtype   <= REQ_WRITE;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAP_MAX_W * MAP_MAX_H - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          rtype <= in_type;
          state <= S_DECODE;
        end
        S_DECODE: begin
          case (rtype)
            REQ_WRITE: state <= S_OUT;
            REQ_QUERY: state <= S_QREAD;
            REQ_CAST:  state <= S_CORDIC;
            default:   state <= S_OUT;
          endcase
        end
        S_QREAD: state <= S_QDONE;
        S_QDONE: state <= S_OUT;
        S_CORDIC: if (sts.cordic_last) state <= S_DIR;
        S_DIR:  state <= S_DIVX;
        S_DIVX: if (sts.div_last) state <= S_DIVY;
        S_DIVY: if (sts.div_last) state <= S_SIDE;
        S_SIDE: state <= S_STEP;
        S_STEP: state <= S_FETCH;
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          if (sts.found) state <= S_HMUL;
          else if (sts.steps_out) state <= S_OUT;
          else state <= S_STEP;
        end
        S_HMUL: state <= S_HFIN;
        S_HFIN: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/grid_dda_ray_traversal_unit.sv
// Top level of the grid DDA ray traversal unit.
// Write and query requests each return a result; a cast runs a 32-step CORDIC,
// two reciprocal divisions and a DDA walk with one map read per step to a hit or a miss.
// One request at a time; the next is taken after the result transaction.
// After reset a clearing pass over all MAP_MAX_W*MAP_MAX_H cells fills the map
// with spaces; requests wait, configuration writes are taken at once.
module grid_dda_ray_traversal_unit import gdda_pkg::*; #(
  parameter int MAP_MAX_W  = MAP_MAX_W_DEF,
  parameter int MAP_MAX_H  = MAP_MAX_H_DEF,
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input logic clk,
  input logic rst,
  gdda_req_if.sink   req,
  gdda_rsp_if.source rsp,
  gdda_cfg_if.sink   cfg
);
  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] map_width, map_height;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 7'd64;
      map_height <= 7'd64;
    end else if (cfg.valid) begin
      if (cfg.data.cfg_index == CFG_MAP_WIDTH) map_width <= cfg.data.cfg_data;
      else if (cfg.data.cfg_index == CFG_MAP_HEIGHT) map_height <= cfg.data.cfg_data;
    end
  end

  gdda_ctrl #(.MAP_MAX_W(MAP_MAX_W), .MAP_MAX_H(MAP_MAX_H)) u_ctrl (
    .clk, .rst,
    .in_valid (req.valid),
    .in_type  (req.data.req_type),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts, .cmd
  );

  gdda_datapath #(.MAP_MAX_W(MAP_MAX_W), .MAP_MAX_H(MAP_MAX_H),
                  .STEP_LIMIT(STEP_LIMIT)) u_dp (
    .clk, .rst, .cmd, .sts,
    .req       (req.data),
    .map_width, .map_height,
    .rsp       (rsp.data)
  );
endmodule
